[src/gsrr_pkg.sv]
// ----------------------------------------------------------------------------
// gsrr_pkg
// Shared types and constants for the game controller shift-register reader.
// ----------------------------------------------------------------------------
package gsrr_pkg;

    // Register map: one 32-bit register every four bytes.
    localparam int unsigned ADDR_W   = 3;
    localparam int unsigned DATA_W   = 32;
    localparam logic        REG_WAIT = 1'b0;
    localparam logic        REG_BITS = 1'b1;

    // Field widths.
    localparam int unsigned WAIT_W  = 8;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned TICK_W  = 8;
    localparam int unsigned WORD_W  = 16;

    // Register reset values.
    localparam logic [WAIT_W-1:0]  WAIT_RESET  = 8'd6;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd12;

    // One result beat as produced by the sequencer.
    typedef struct packed {
        logic              clock_pin;
        logic              latch_pin;
        logic [WORD_W-1:0] buttons;
        logic              word_done;
    } t_result;

endpackage

[src/gsrr_seq.sv]
// ----------------------------------------------------------------------------
// gsrr_seq
// Poll sequencer: advances one phase per accepted tick and forms the result
// beat for that tick from the current state and the incoming data level.
// ----------------------------------------------------------------------------
module gsrr_seq (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    input  logic                             i_data_level,
    input  logic [gsrr_pkg::WAIT_W-1:0]      i_wait_ticks,
    input  logic [gsrr_pkg::COUNT_W-1:0]     i_bit_count,
    output gsrr_pkg::t_result                o_result
);
    import gsrr_pkg::*;

    typedef enum logic [3:0] {
        PH_START       = 4'd0,
        PH_INIT        = 4'd1,
        PH_WAIT        = 4'd2,
        PH_LATCH       = 4'd3,
        PH_LATCH_AFTER = 4'd4,
        PH_DATA        = 4'd5,
        PH_CLOCK       = 4'd6,
        PH_FINISH      = 4'd7,
        PH_PRE         = 4'd8
    } t_phase;

    t_phase              r_phase,      n_phase;
    logic [TICK_W-1:0]   r_tick_count, n_tick_count;
    logic [WORD_W-1:0]   r_shift_word, n_shift_word;
    logic [WORD_W-1:0]   r_held_word,  n_held_word;
    logic [TICK_W-1:0]   w_tick_inc;
    logic [TICK_W-1:0]   w_bit_count_ext;
    logic [WORD_W-1:0]   w_bit;

    assign w_tick_inc      = r_tick_count + TICK_W'(1);
    assign w_bit_count_ext = TICK_W'(i_bit_count);
    // The data line is active low.
    assign w_bit           = {{(WORD_W-1){1'b0}}, ~i_data_level};

    // Phase transition, decided on the state before this tick's update.
    always_comb begin
        unique case (r_phase)
            PH_START:       n_phase = PH_INIT;
            PH_INIT:        n_phase = PH_WAIT;
            PH_WAIT:        n_phase = (r_tick_count >= i_wait_ticks) ? PH_LATCH : PH_WAIT;
            PH_LATCH:       n_phase = PH_LATCH_AFTER;
            PH_LATCH_AFTER: n_phase = PH_DATA;
            PH_DATA:        n_phase = PH_CLOCK;
            PH_CLOCK:       n_phase = (r_tick_count >= w_bit_count_ext) ? PH_FINISH : PH_DATA;
            PH_FINISH:      n_phase = PH_WAIT;
            default:        n_phase = PH_START;
        endcase
    end

    // Work done in the phase just entered, and the pins for this tick.
    always_comb begin
        n_tick_count       = r_tick_count;
        n_shift_word       = r_shift_word;
        n_held_word        = r_held_word;
        o_result.clock_pin = 1'b0;
        o_result.latch_pin = 1'b0;
        o_result.word_done = 1'b0;
        unique case (n_phase)
            PH_INIT: begin
                n_tick_count = '0;
                n_held_word  = '0;
                n_shift_word = '0;
            end
            PH_WAIT: begin
                n_tick_count = w_tick_inc;
                n_shift_word = '0;
            end
            PH_LATCH: begin
                o_result.latch_pin = 1'b1;
                n_tick_count       = '0;
            end
            PH_DATA: begin
                n_shift_word = r_shift_word | w_bit;
            end
            PH_CLOCK: begin
                o_result.clock_pin = 1'b1;
                n_tick_count       = w_tick_inc;
                // Shift only while more bits are still to come.
                if (w_tick_inc < w_bit_count_ext) begin
                    n_shift_word = {r_shift_word[WORD_W-2:0], 1'b0};
                end
            end
            PH_FINISH: begin
                n_tick_count       = '0;
                n_held_word        = r_shift_word;
                o_result.word_done = 1'b1;
            end
            default: begin
            end
        endcase
        o_result.buttons = n_held_word;
    end

    // Sequencer state, advanced once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_PRE;
            r_tick_count <= '0;
            r_shift_word <= '0;
            r_held_word  <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_tick_count <= n_tick_count;
            r_shift_word <= n_shift_word;
            r_held_word  <= n_held_word;
        end
    end

    // The init tick clears both words.
    a_init_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && n_phase == PH_INIT |=> r_held_word == '0 && r_shift_word == '0)
        else $error("init tick did not clear the words");

    // The finish tick publishes the gathered word.
    a_finish_publish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && n_phase == PH_FINISH |=> r_held_word == $past(r_shift_word))
        else $error("finish tick did not publish the shift word");

    // The latch pulse restarts the bit counter.
    a_latch_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && n_phase == PH_LATCH |=> r_tick_count == '0 && r_phase == PH_LATCH)
        else $error("latch tick did not restart the counter");

    // The held word only moves on an init or finish tick.
    a_held_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_step && (n_phase == PH_INIT || n_phase == PH_FINISH)) |=> $stable(r_held_word))
        else $error("held word changed outside init or finish");

endmodule

[src/gamepad_shift_register_reader_core.sv]
// ----------------------------------------------------------------------------
// gamepad_shift_register_reader_core
// Polls a serial game controller one tick per input beat and reports the
// clock and latch pins, the last button word and a done flag per tick.
// ----------------------------------------------------------------------------
// Each input beat is one tick and yields exactly one result beat. The block
// takes a new beat every cycle unless the output register holds a beat that
// is not being taken: the sequencer state updates in the cycle of acceptance
// and the result waits in a single output register, which is refilled in the
// same cycle it is taken. Throughput is one tick per cycle without stalls.
// Registers wait_ticks (0x0) and bit_count (0x4) are read and written over
// the APB port and should be written while no result beat is pending.
module gamepad_shift_register_reader_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gsrr_pkg::ADDR_W-1:0]     paddr,
    input  logic [gsrr_pkg::DATA_W-1:0]     pwdata,
    output logic [gsrr_pkg::DATA_W-1:0]     prdata,
    output logic                            pready,
    // Tick input.
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_data_level,
    // Result output.
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_clock_pin,
    output logic                            o_latch_pin,
    output logic [gsrr_pkg::WORD_W-1:0]     o_buttons,
    output logic                            o_word_done
);
    import gsrr_pkg::*;

    logic [WAIT_W-1:0]  r_wait_ticks;
    logic [COUNT_W-1:0] r_bit_count;
    logic               r_out_valid;
    t_result            r_result;
    t_result            w_result;
    logic               w_step;
    logic               w_cfg_write;

    // Configuration registers.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_ticks <= WAIT_RESET;
            r_bit_count  <= COUNT_RESET;
        end else if (w_cfg_write) begin
            unique case (paddr[2])
                REG_WAIT: r_wait_ticks <= pwdata[WAIT_W-1:0];
                REG_BITS: r_bit_count  <= pwdata[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WAIT: prdata = DATA_W'(r_wait_ticks);
            REG_BITS: prdata = DATA_W'(r_bit_count);
            default:  prdata = '0;
        endcase
    end

    // A tick is taken whenever the output register is free or being drained.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_step     = i_in_valid && o_in_ready;

    gsrr_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_data_level (i_data_level),
        .i_wait_ticks (r_wait_ticks),
        .i_bit_count  (r_bit_count),
        .o_result     (w_result)
    );

    // Output register holding one result beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_clock_pin = r_result.clock_pin;
    assign o_latch_pin = r_result.latch_pin;
    assign o_buttons   = r_result.buttons;
    assign o_word_done = r_result.word_done;

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the game controller shift-register reader. A
// driver sends data-line ticks from a queue, and a monitor checks each
// result beat against a cycle model of the poll sequencer. The run covers
// reset values, extreme and random register settings, and random stalls on
// both channels.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import gsrr_pkg::*;

    // Poll sequencer phases as the bench models them.
    typedef enum logic [3:0] {
        SEQ_START     = 4'd0,
        SEQ_INIT      = 4'd1,
        SEQ_WAIT      = 4'd2,
        SEQ_LATCH     = 4'd3,
        SEQ_LATCH_GAP = 4'd4,
        SEQ_SAMPLE    = 4'd5,
        SEQ_CLOCK_HI  = 4'd6,
        SEQ_FINISH    = 4'd7,
        SEQ_PRE       = 4'd8
    } t_seq;

    localparam int unsigned IDLE_PCT = 24;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [ADDR_W-1:0]   paddr        = '0;
    logic [DATA_W-1:0]   pwdata       = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                i_in_valid   = 1'b0;
    logic                o_in_ready;
    logic                i_data_level = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready  = 1'b0;
    logic                o_clock_pin;
    logic                o_latch_pin;
    logic [WORD_W-1:0]   o_buttons;
    logic                o_word_done;

    // Bench-side copy of the registers and the sequencer state.
    logic [WAIT_W-1:0]   model_wait  = WAIT_RESET;
    logic [COUNT_W-1:0]  model_bits  = COUNT_RESET;
    t_seq                model_seq   = SEQ_PRE;
    logic [TICK_W-1:0]   model_ticks = '0;
    logic [WORD_W-1:0]   model_shift = '0;
    logic [WORD_W-1:0]   model_held  = '0;

    logic                tick_levels[$];
    t_result             pending_pins[$];
    logic                tick_taken  = 1'b0;
    logic                steady_flow = 1'b0;
    int                  error_count = 0;
    int                  ticks_sent  = 0;
    int                  words_seen  = 0;
    int                  settings    = 1;

    gamepad_shift_register_reader_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_level (i_data_level),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_clock_pin  (o_clock_pin),
        .o_latch_pin  (o_latch_pin),
        .o_buttons    (o_buttons),
        .o_word_done  (o_word_done)
    );

    always #5 i_clk = ~i_clk;

    // Advance the sequencer model by one tick and return the pins it drives.
    function automatic t_result poll_tick(input logic level);
        t_result     pins;
        logic        pressed;
        pressed = ~level;
        pins    = '0;
        case (model_seq)
            SEQ_START:     model_seq = SEQ_INIT;
            SEQ_INIT:      model_seq = SEQ_WAIT;
            SEQ_WAIT:      model_seq = (model_ticks >= model_wait) ? SEQ_LATCH : SEQ_WAIT;
            SEQ_LATCH:     model_seq = SEQ_LATCH_GAP;
            SEQ_LATCH_GAP: model_seq = SEQ_SAMPLE;
            SEQ_SAMPLE:    model_seq = SEQ_CLOCK_HI;
            SEQ_CLOCK_HI:  model_seq = (model_ticks >= model_bits) ? SEQ_FINISH : SEQ_SAMPLE;
            SEQ_FINISH:    model_seq = SEQ_WAIT;
            default:       model_seq = SEQ_START;
        endcase
        case (model_seq)
            SEQ_INIT: begin
                model_ticks = '0;
                model_held  = '0;
                model_shift = '0;
            end
            SEQ_WAIT: begin
                model_ticks = model_ticks + 1'b1;
                model_shift = '0;
            end
            SEQ_LATCH: begin
                pins.latch_pin = 1'b1;
                model_ticks    = '0;
            end
            SEQ_SAMPLE: begin
                model_shift[0] = model_shift[0] | pressed;
            end
            SEQ_CLOCK_HI: begin
                model_ticks    = model_ticks + 1'b1;
                pins.clock_pin = 1'b1;
                if (model_ticks < model_bits) begin
                    model_shift = model_shift << 1;
                end
            end
            SEQ_FINISH: begin
                model_ticks    = '0;
                model_held     = model_shift;
                pins.word_done = 1'b1;
            end
            default: begin
            end
        endcase
        pins.buttons = model_held;
        return pins;
    endfunction

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            error_count++;
            if (error_count <= 30) begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, want, got);
            end
        end
    endtask

    // Driver: a beat stays on the bus until the edge that takes it.
    always @(negedge i_clk) begin
        if (!i_in_valid || tick_taken) begin
            if (i_rst_n && tick_levels.size() > 0 &&
                (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
                i_in_valid   <= 1'b1;
                i_data_level <= tick_levels.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: track register writes, predict accepted ticks, check results.
    always @(posedge i_clk) begin
        t_result want;
        tick_taken = 1'b0;
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == {REG_WAIT, 2'b00}) begin
                    model_wait = pwdata[WAIT_W-1:0];
                end else if (paddr == {REG_BITS, 2'b00}) begin
                    model_bits = pwdata[COUNT_W-1:0];
                end
            end
            if (i_in_valid && o_in_ready) begin
                tick_taken = 1'b1;
                ticks_sent++;
                pending_pins.push_back(poll_tick(i_data_level));
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_pins.size() == 0) begin
                    error_count++;
                    $display("%0t: result beat with none expected, actual buttons 0x%0h",
                             $time, o_buttons);
                end else begin
                    want = pending_pins.pop_front();
                    check_field("clock_pin", want.clock_pin, o_clock_pin);
                    check_field("latch_pin", want.latch_pin, o_latch_pin);
                    check_field("buttons", want.buttons, o_buttons);
                    check_field("word_done", want.word_done, o_word_done);
                    if (want.word_done) begin
                        words_seen++;
                    end
                end
            end
        end
    end

    // Write one register over APB and read it back.
    task automatic write_reg(input logic idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] mask;
        mask = (idx == REG_WAIT) ? 32'h0000_00FF : 32'h0000_001F;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        check_field("register readback", value, prdata & mask);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Hold off until every tick has gone out and every result has come back.
    task automatic settle();
        while (tick_levels.size() != 0 || i_in_valid || pending_pins.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (3) @(negedge i_clk);
    endtask

    task automatic set_config(input int unsigned wait_val, input int unsigned bits_val);
        settle();
        write_reg(REG_WAIT, wait_val);
        write_reg(REG_BITS, bits_val);
        settings++;
    endtask

    task automatic queue_random(input int unsigned count);
        for (int unsigned n = 0; n < count; n++) begin
            tick_levels.push_back(1'($urandom_range(1)));
        end
    endtask

    // Stimulus sequence.
    initial begin
        logic [23:0] pattern;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: one full poll of twelve bits and part of a second.
        queue_random(60);

        // Shortest poll, one bit per word, both data levels.
        set_config(0, 1);
        pattern = 24'b0101_1100_0011_0110_1001_1110;
        for (int n = 0; n < 24; n++) begin
            tick_levels.push_back(pattern[n]);
        end

        // Shortest wait with full sixteen-bit words and no stalls at all;
        // long runs of one level give all-ones and all-zeros words.
        set_config(0, 16);
        steady_flow = 1'b1;
        for (int n = 0; n < 40; n++) tick_levels.push_back(1'b0);
        for (int n = 0; n < 40; n++) tick_levels.push_back(1'b1);
        queue_random(20);
        settle();
        steady_flow = 1'b0;

        // Longest wait and widest word.
        set_config(255, 16);
        queue_random(300);

        // Mid-range settings, then a few random ones.
        set_config(3, 8);
        queue_random(80);
        for (int p = 0; p < 3; p++) begin
            set_config($urandom_range(8), $urandom_range(16, 1));
            queue_random(40);
        end

        settle();
        repeat (5) @(posedge i_clk);
        if (pending_pins.size() != 0) begin
            error_count++;
            $display("%0t: %0d result beats never arrived", $time, pending_pins.size());
        end
        $display("Sent %0d ticks under %0d register settings; %0d button words published.",
                 ticks_sent, settings, words_seen);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog for a stuck handshake.
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
